>>> hdl/deqr_pkg.sv
// ----------------------------------------------------------------------------
// deqr_pkg
// Shared types and constants for the double-ended queue with remove.
// ----------------------------------------------------------------------------
package deqr_pkg;

	localparam int DEQR_DEPTH      = 64;
	localparam int DEQR_DATA_WIDTH = 32;
	localparam int VALUE_W         = 32;
	localparam int COUNT_W         = 7;
	localparam int ACTION_W        = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_POP_BACK   = 3'd1,
		ACT_PUSH_FRONT = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_REMOVE     = 3'd4,
		ACT_CLEAR      = 3'd5
	} action_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [VALUE_W-1:0]  item_value;
	} deqr_in_t;

	typedef struct packed {
		logic [VALUE_W-1:0] popped_value;
		logic               popped_valid;
		logic               fault;
		logic [COUNT_W-1:0] item_count;
	} deqr_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic rm_step;
		logic load;
	} deqr_cmd_t;

	typedef struct packed {
		logic rm_done;
		logic out_free;
	} deqr_sts_t;

endpackage

>>> hdl/deqr_ram.sv
// ----------------------------------------------------------------------------
// deqr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deqr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/deqr_ctrl.sv
// ----------------------------------------------------------------------------
// deqr_ctrl
// Sequencer: accepts one item, runs the remove walk for a remove, hands off the result.
// ----------------------------------------------------------------------------
module deqr_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [deqr_pkg::ACTION_W-1:0] in_action,
	output logic                          in_stall,
	input  deqr_pkg::deqr_sts_t           sts,
	output deqr_pkg::deqr_cmd_t           cmd
);
	import deqr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					if (in_action == ACT_REMOVE) begin
						state_d = ST_REMOVE;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_REMOVE: begin
				cmd.rm_step = 1'b1;
				if (sts.rm_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/deqr_dpath.sv
// ----------------------------------------------------------------------------
// deqr_dpath
// Queue storage, ring indices, remove walker and result register.
// ----------------------------------------------------------------------------
module deqr_dpath #(
	parameter int DEPTH      = deqr_pkg::DEQR_DEPTH,
	parameter int DATA_WIDTH = deqr_pkg::DEQR_DATA_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  deqr_pkg::deqr_in_t   cmd_in,
	input  deqr_pkg::deqr_cmd_t  cmd,
	output deqr_pkg::deqr_sts_t  sts,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output deqr_pkg::deqr_out_t  rsp
);
	import deqr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
	endfunction

	logic [AW-1:0]         front_q, back_q, rd_q, wr_q;
	logic [CW-1:0]         count_q, left_q, kept_q;
	logic                  pend_q, fault_q, popv_q, out_valid_q;
	logic [DATA_WIDTH-1:0] val_q;
	deqr_out_t             out_q;

	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	logic [DATA_WIDTH+VALUE_W-1:0] in_wide;
	logic [DATA_WIDTH-1:0]         in_val;
	logic [DATA_WIDTH+VALUE_W-1:0] rd_wide;
	logic [CW+COUNT_W-1:0]         cnt_wide;
	logic                          full, empty, keep, rm_done;

	assign in_wide  = {{DATA_WIDTH{1'b0}}, cmd_in.item_value};
	assign in_val   = in_wide[DATA_WIDTH-1:0];
	assign rd_wide  = {{VALUE_W{1'b0}}, ram_rdata};
	assign cnt_wide = {{COUNT_W{1'b0}}, count_q};

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign keep    = pend_q && (ram_rdata != val_q);
	assign rm_done = (left_q == '0) && !pend_q;

	assign sts.rm_done  = rm_done;
	assign sts.out_free = !out_valid_q || !rsp_stall;

	deqr_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = in_val;
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (cmd.start) begin
			case (cmd_in.action)
				ACT_PUSH_BACK: begin
					ram_we    = !full;
					ram_waddr = idx_next(back_q);
				end
				ACT_PUSH_FRONT: begin
					ram_we    = !full;
					ram_waddr = idx_prev(front_q);
				end
				ACT_POP_BACK: begin
					ram_re    = !empty;
					ram_raddr = back_q;
				end
				ACT_POP_FRONT: begin
					ram_re    = !empty;
					ram_raddr = front_q;
				end
				default: begin
				end
			endcase
		end else if (cmd.rm_step) begin
			ram_re    = (left_q != '0);
			ram_raddr = rd_q;
			ram_we    = keep;
			ram_waddr = wr_q;
			ram_wdata = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= AW'(DEPTH - 1);
			count_q <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			left_q  <= '0;
			kept_q  <= '0;
			pend_q  <= 1'b0;
		end else if (cmd.start) begin
			case (cmd_in.action)
				ACT_PUSH_BACK: begin
					if (!full) begin
						back_q  <= idx_next(back_q);
						count_q <= count_q + CW'(1);
					end
				end
				ACT_PUSH_FRONT: begin
					if (!full) begin
						front_q <= idx_prev(front_q);
						count_q <= count_q + CW'(1);
					end
				end
				ACT_POP_BACK: begin
					if (!empty) begin
						back_q  <= idx_prev(back_q);
						count_q <= count_q - CW'(1);
					end
				end
				ACT_POP_FRONT: begin
					if (!empty) begin
						front_q <= idx_next(front_q);
						count_q <= count_q - CW'(1);
					end
				end
				ACT_REMOVE: begin
					rd_q   <= front_q;
					wr_q   <= front_q;
					left_q <= count_q;
					kept_q <= '0;
					pend_q <= 1'b0;
				end
				ACT_CLEAR: begin
					front_q <= '0;
					back_q  <= AW'(DEPTH - 1);
					count_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.rm_step) begin
			pend_q <= (left_q != '0);
			if (left_q != '0) begin
				rd_q   <= idx_next(rd_q);
				left_q <= left_q - CW'(1);
			end
			if (keep) begin
				wr_q   <= idx_next(wr_q);
				kept_q <= kept_q + CW'(1);
			end
			if (rm_done) begin
				count_q <= kept_q;
				back_q  <= idx_prev(wr_q);
			end
		end
	end

	// pending result flags and compare value
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			val_q <= in_val;
			case (cmd_in.action)
				ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
					fault_q <= full;
					popv_q  <= 1'b0;
				end
				ACT_POP_BACK, ACT_POP_FRONT: begin
					fault_q <= empty;
					popv_q  <= !empty;
				end
				default: begin
					fault_q <= 1'b0;
					popv_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.popped_value <= popv_q ? rd_wide[VALUE_W-1:0] : '0;
			out_q.popped_valid <= popv_q;
			out_q.fault        <= fault_q;
			out_q.item_count   <= cnt_wide[COUNT_W-1:0];
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

>>> hdl/double_ended_queue_with_remove_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_remove_unit
// Bounded double-ended queue in a circular RAM with remove-by-value and clear.
// ----------------------------------------------------------------------------
// One item in, one item out. Push, pop, clear and unused actions are accepted
// in the idle state, which does the RAM write or issues the RAM read; the
// finish state then moves the result into the output register once it is free.
// Remove walks the live entries through the RAM read port one per cycle,
// compacting kept words through the write port behind it.
// A new item is taken once the previous result sits in the output register,
// even if it has not been taken yet. Push to a full queue or pop from an
// empty one sets fault and leaves the queue unchanged.
module double_ended_queue_with_remove_unit #(
	parameter int DEPTH      = deqr_pkg::DEQR_DEPTH,
	parameter int DATA_WIDTH = deqr_pkg::DEQR_DATA_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  deqr_pkg::deqr_in_t  cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output deqr_pkg::deqr_out_t rsp
);
	import deqr_pkg::*;

	deqr_cmd_t ctl_cmd;
	deqr_sts_t ctl_sts;

	deqr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_valid),
		.in_action(cmd.action),
		.in_stall (cmd_stall),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	deqr_dpath #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_in   (cmd),
		.cmd      (ctl_cmd),
		.sts      (ctl_sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-ended queue with remove-by-value.
// A short table of directed items covers the empty and unused-action cases,
// pushes and pops at both ends, and remove and clear. Random phases follow:
// a mixed workload, a fill burst while the receiver holds off, remove-heavy
// traffic, a drain past empty, and another
// mixed workload. Every item is run through a local deque model, and each
// result is compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
	import deqr_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [VALUE_W-1:0]  val;
		logic                chk;
		deqr_out_t           res;
	} plan_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	deqr_in_t  cmd       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	deqr_out_t rsp;

	// fixed result riding along with a directed item
	logic      fixed_chk = 1'b0;
	deqr_out_t fixed_res = '0;

	deqr_out_t pending_results[$];
	int        fail_n  = 0;
	int        cycle_n = 0;
	bit        hold_rsp = 1'b0;
	bit        cmd_calm = 1'b0;
	bit        rsp_calm = 1'b0;

	// deque model state
	logic [VALUE_W-1:0] slot_mem [DEQR_DEPTH];
	int unsigned        head_ix = 0;
	int unsigned        tail_ix = DEQR_DEPTH - 1;
	int unsigned        live_n  = 0;

	plan_row_t plan [21] = '{
		'{ACT_POP_BACK,   32'h0,        1'b1, '{32'h0,        1'b0, 1'b1, 7'd0}},
		'{ACT_POP_FRONT,  32'h0,        1'b1, '{32'h0,        1'b0, 1'b1, 7'd0}},
		'{ACT_REMOVE,     32'h0,        1'b1, '{32'h0,        1'b0, 1'b0, 7'd0}},
		'{ACT_SPARE_LO,   32'h0,        1'b1, '{32'h0,        1'b0, 1'b0, 7'd0}},
		'{ACT_PUSH_BACK,  32'hFFFFFFFF, 1'b1, '{32'h0,        1'b0, 1'b0, 7'd1}},
		'{ACT_PUSH_FRONT, 32'h0,        1'b1, '{32'h0,        1'b0, 1'b0, 7'd2}},
		'{ACT_PUSH_BACK,  32'h12345678, 1'b0, '0},
		'{ACT_PUSH_FRONT, 32'hFFFFFFFF, 1'b0, '0},
		'{ACT_REMOVE,     32'hFFFFFFFF, 1'b1, '{32'h0,        1'b0, 1'b0, 7'd2}},
		'{ACT_POP_FRONT,  32'hDEADBEEF, 1'b1, '{32'h0,        1'b1, 1'b0, 7'd1}},
		'{ACT_POP_BACK,   32'h0,        1'b1, '{32'h12345678, 1'b1, 1'b0, 7'd0}},
		'{ACT_SPARE_HI,   32'hFFFFFFFF, 1'b1, '{32'h0,        1'b0, 1'b0, 7'd0}},
		'{ACT_PUSH_BACK,  32'h80000001, 1'b0, '0},
		'{ACT_PUSH_BACK,  32'h80000001, 1'b0, '0},
		'{ACT_PUSH_FRONT, 32'h7,        1'b0, '0},
		'{ACT_REMOVE,     32'h3,        1'b0, '0},
		'{ACT_REMOVE,     32'h80000001, 1'b0, '0},
		'{ACT_POP_BACK,   32'h0,        1'b0, '0},
		'{ACT_PUSH_FRONT, 32'h55555555, 1'b0, '0},
		'{ACT_CLEAR,      32'hAAAAAAAA, 1'b1, '{32'h0,        1'b0, 1'b0, 7'd0}},
		'{ACT_POP_FRONT,  32'h0,        1'b1, '{32'h0,        1'b0, 1'b1, 7'd0}}
	};

	double_ended_queue_with_remove_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic deqr_out_t deque_apply(deqr_in_t it);
		deqr_out_t   r;
		int unsigned rd;
		int unsigned wr;
		int unsigned kept;
		r = '0;
		case (it.action)
			ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
				if (live_n >= DEQR_DEPTH) begin
					r.fault = 1'b1;
				end else if (it.action == ACT_PUSH_BACK) begin
					tail_ix = (tail_ix + 1) % DEQR_DEPTH;
					slot_mem[tail_ix] = it.item_value;
					live_n++;
				end else begin
					head_ix = (head_ix + DEQR_DEPTH - 1) % DEQR_DEPTH;
					slot_mem[head_ix] = it.item_value;
					live_n++;
				end
			end
			ACT_POP_BACK, ACT_POP_FRONT: begin
				if (live_n == 0) begin
					r.fault = 1'b1;
				end else if (it.action == ACT_POP_BACK) begin
					r.popped_value = slot_mem[tail_ix];
					r.popped_valid = 1'b1;
					tail_ix = (tail_ix + DEQR_DEPTH - 1) % DEQR_DEPTH;
					live_n--;
				end else begin
					r.popped_value = slot_mem[head_ix];
					r.popped_valid = 1'b1;
					head_ix = (head_ix + 1) % DEQR_DEPTH;
					live_n--;
				end
			end
			ACT_REMOVE: begin
				rd = head_ix;
				wr = head_ix;
				kept = 0;
				for (int n = 0; n < live_n; n++) begin
					if (slot_mem[rd] != it.item_value) begin
						slot_mem[wr] = slot_mem[rd];
						wr = (wr + 1) % DEQR_DEPTH;
						kept++;
					end
					rd = (rd + 1) % DEQR_DEPTH;
				end
				live_n = kept;
				tail_ix = (wr + DEQR_DEPTH - 1) % DEQR_DEPTH;
			end
			ACT_CLEAR: begin
				head_ix = 0;
				tail_ix = DEQR_DEPTH - 1;
				live_n = 0;
			end
			default: begin
			end
		endcase
		r.item_count = COUNT_W'(live_n);
		return r;
	endfunction

	function automatic logic [ACTION_W-1:0] draw_action(int push_w, int pop_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_w)
			return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
		if (r < push_w + pop_w)
			return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
		if (r < 96)
			return ACT_REMOVE;
		if (r < 98)
			return ACT_CLEAR;
		return (r == 98) ? ACT_SPARE_LO : ACT_SPARE_HI;
	endfunction

	// small words so removes find matches, full-range words for bit coverage
	function automatic logic [VALUE_W-1:0] draw_value();
		case ($urandom_range(0, 3))
			0, 1: return VALUE_W'($urandom_range(0, 7));
			2: return $urandom();
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	task automatic offer(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
			input logic chk, input deqr_out_t res);
		int gap;
		if ($urandom_range(0, 29) == 0)
			cmd_calm = !cmd_calm;
		gap = cmd_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{action: act, item_value: val};
		fixed_chk <= chk;
		fixed_res <= res;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic wait_results_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	initial begin : rsp_side
		int gap;
		wait (arst_n);
		forever begin
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				if ($urandom_range(0, 29) == 0)
					rsp_calm = !rsp_calm;
				gap = rsp_calm ? 0 : $urandom_range(0, 19);
				if (gap > 0) begin
					rsp_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	always @(posedge clk) begin
		deqr_out_t want;
		deqr_out_t model_out;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result %p", rsp);
					fail_n++;
				end else begin
					want = pending_results.pop_front();
					if (rsp.popped_value !== want.popped_value) begin
						$error("popped_value expected %h actual %h",
							want.popped_value, rsp.popped_value);
						fail_n++;
					end
					if (rsp.popped_valid !== want.popped_valid) begin
						$error("popped_valid expected %b actual %b",
							want.popped_valid, rsp.popped_valid);
						fail_n++;
					end
					if (rsp.fault !== want.fault) begin
						$error("fault expected %b actual %b", want.fault, rsp.fault);
						fail_n++;
					end
					if (rsp.item_count !== want.item_count) begin
						$error("item_count expected %0d actual %0d",
							want.item_count, rsp.item_count);
						fail_n++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				model_out = deque_apply(cmd);
				pending_results.push_back(fixed_chk ? fixed_res : model_out);
			end
		end
	end

	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : cmd_side
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer(plan[i].act, plan[i].val, plan[i].chk, plan[i].res);

		repeat (200) offer(draw_action(50, 35), draw_value(), 1'b0, '0);
		wait_results_drained();

		// fill past full while the receiver holds off
		hold_rsp = 1'b1;
		repeat (72)
			offer($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, draw_value(),
				1'b0, '0);

		repeat (150) offer(draw_action(40, 20), draw_value(), 1'b0, '0);

		repeat (72)
			offer($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, draw_value(),
				1'b0, '0);

		repeat (200) offer(draw_action(45, 45), draw_value(), 1'b0, '0);

		wait_results_drained();
		repeat (80) @(posedge clk);
		if (fail_n == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
